[hdl/bllr_pkg.sv]
// Shared types, constants and the character classifier of the bidi line reorderer.
`timescale 1ns / 1ps

package bllr_pkg;

    localparam int MAX_CHARS_DEF = 64;
    localparam int IDX_W = 6;
    localparam int CP_W  = 21;
    localparam int LEN_W = 3;
    localparam int OFF_W = 8;
    localparam int BT_W  = 9;
    localparam int LVL_W = 2;
    localparam int CLS_W = 4;

    typedef logic [CLS_W-1:0] t_class;
    typedef logic [3:0]       t_pass;

    localparam t_class C_L   = 4'd0;
    localparam t_class C_R   = 4'd1;
    localparam t_class C_AL  = 4'd2;
    localparam t_class C_EN  = 4'd3;
    localparam t_class C_AN  = 4'd4;
    localparam t_class C_ES  = 4'd5;
    localparam t_class C_ET  = 4'd6;
    localparam t_class C_CS  = 4'd7;
    localparam t_class C_NSM = 4'd8;
    localparam t_class C_B   = 4'd9;
    localparam t_class C_S   = 4'd10;
    localparam t_class C_WS  = 4'd11;
    localparam t_class C_ON  = 4'd12;
    // Neutral marked during the backward neutral pass with the strong type on its right.
    localparam t_class C_NRL = 4'd13;
    localparam t_class C_NRR = 4'd14;

    localparam t_pass P_W123 = 4'd0;
    localparam t_pass P_W4   = 4'd1;
    localparam t_pass P_W5F  = 4'd2;
    localparam t_pass P_W5B  = 4'd3;
    localparam t_pass P_W67  = 4'd4;
    localparam t_pass P_NPRE = 4'd5;
    localparam t_pass P_NRES = 4'd6;
    localparam t_pass P_LVL  = 4'd7;
    localparam t_pass P_ORD  = 4'd8;

    localparam logic [LVL_W-1:0] LV_0 = 2'd0;
    localparam logic [LVL_W-1:0] LV_1 = 2'd1;
    localparam logic [LVL_W-1:0] LV_2 = 2'd2;

    typedef struct packed {
        logic             load_we;
        logic             load_drop;
        logic [IDX_W-1:0] load_addr;
        t_pass            pass;
        logic             proc_en;
        logic             first;
        logic             has_next;
        logic [IDX_W-1:0] rd_addr;
        logic [IDX_W-1:0] proc_addr;
        logic             emit_st;
        logic             emit_load;
        logic             emit_last;
        logic             clear_line;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic rng(input logic [CP_W-1:0] v, input logic [CP_W-1:0] lo,
                                 input logic [CP_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic t_class classify(input logic [CP_W-1:0] cp);
        t_class c;
        if (cp == 21'h0A || cp == 21'h0D || cp == 21'h2029) c = C_B;
        else if (cp == 21'h09 || cp == 21'h0B || cp == 21'h1F) c = C_S;
        else if (cp == 21'h20 || cp == 21'hA0 || cp == 21'h202F || cp == 21'h205F ||
                 cp == 21'h3000 || cp == 21'h0C) c = C_WS;
        else if (rng(cp, 21'h2000, 21'h200A)) c = C_WS;
        else if (rng(cp, 21'h0591, 21'h05BD)) c = C_NSM;
        else if (cp == 21'h05BF || cp == 21'h05C1 || cp == 21'h05C2 || cp == 21'h05C4 ||
                 cp == 21'h05C5 || cp == 21'h05C7) c = C_NSM;
        else if (rng(cp, 21'h0590, 21'h05FF)) c = C_R;
        else if (rng(cp, 21'h07C0, 21'h085F)) c = C_R;
        else if (rng(cp, 21'hFB1D, 21'hFB4F)) c = C_R;
        else if (rng(cp, 21'h0610, 21'h061A) || rng(cp, 21'h064B, 21'h065F) ||
                 cp == 21'h0670 || rng(cp, 21'h06D6, 21'h06DC) ||
                 rng(cp, 21'h06DF, 21'h06E4) || cp == 21'h06E7 || cp == 21'h06E8 ||
                 rng(cp, 21'h06EA, 21'h06ED)) c = C_NSM;
        else if (rng(cp, 21'h0660, 21'h0669)) c = C_AN;
        else if (rng(cp, 21'h06F0, 21'h06F9)) c = C_EN;
        else if (rng(cp, 21'h0600, 21'h06FF) || rng(cp, 21'h0750, 21'h077F) ||
                 rng(cp, 21'h08A0, 21'h08FF) || rng(cp, 21'hFB50, 21'hFDFF) ||
                 rng(cp, 21'hFE70, 21'hFEFF)) c = C_AL;
        else if (rng(cp, 21'h0300, 21'h036F) || rng(cp, 21'h1AB0, 21'h1AFF) ||
                 rng(cp, 21'h1DC0, 21'h1DFF) || rng(cp, 21'h20D0, 21'h20FF)) c = C_NSM;
        else if (rng(cp, 21'h30, 21'h39) || rng(cp, 21'h2070, 21'h2079) ||
                 rng(cp, 21'h2080, 21'h2089)) c = C_EN;
        else if (cp == 21'h2C || cp == 21'h2E || cp == 21'h3A) c = C_CS;
        else if (cp == 21'h2B || cp == 21'h2D || cp == 21'h207A || cp == 21'h207B ||
                 cp == 21'h208A || cp == 21'h208B) c = C_ES;
        else if (cp == 21'h24 || cp == 21'h25 || rng(cp, 21'hA2, 21'hA5) || cp == 21'hB0 ||
                 cp == 21'h2030 || cp == 21'h2031) c = C_ET;
        else if (rng(cp, 21'h41, 21'h5A) || rng(cp, 21'h61, 21'h7A)) c = C_L;
        else if (cp < 21'h20 || cp == 21'h7F) c = C_ON;
        else if (rng(cp, 21'h21, 21'h2F) || rng(cp, 21'h3A, 21'h40) ||
                 rng(cp, 21'h5B, 21'h60) || rng(cp, 21'h7B, 21'h7E)) c = C_ON;
        else c = C_L;
        return c;
    endfunction

    function automatic logic is_neutral(input t_class c);
        return (c == C_B) || (c == C_S) || (c == C_WS) || (c == C_ON);
    endfunction

    function automatic t_class n_view(input t_class c);
        return (c == C_EN || c == C_AN) ? C_R : c;
    endfunction

endpackage

[hdl/bllr_if.sv]
// Valid/ready channel interfaces for the input characters and the visual results.
`timescale 1ns / 1ps

interface bllr_in_if;
    import bllr_pkg::*;
    logic             valid;
    logic             ready;
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] byte_length;
    logic             last_char;
    modport source (output valid, code_point, byte_length, last_char, input ready);
    modport sink (input valid, code_point, byte_length, last_char, output ready);
endinterface

interface bllr_out_if;
    import bllr_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] logical_index;
    logic [LVL_W-1:0] char_level;
    logic [OFF_W-1:0] byte_offset;
    logic [LEN_W-1:0] byte_count;
    logic             last_result;
    logic             overflow;
    modport source (output valid, logical_index, char_level, byte_offset, byte_count,
                    last_result, overflow, input ready);
    modport sink (input valid, logical_index, char_level, byte_offset, byte_count,
                  last_result, overflow, output ready);
endinterface

[hdl/bidi_line_level_reorder_unit.sv]
// Top level of the bidi line reorderer: channels, configuration register and checks.
`timescale 1ns / 1ps

// Usage: a line is sent on the input channel one character per transfer, in logical
// order, each with its code point and UTF-8 length; last_char marks the final one.
// Loading takes one character per cycle. Up to MAX_CHARS characters are kept; later
// ones are dropped and every result of that line carries the overflow flag.
// After the last character the block runs nine passes over the stored line, each
// bounded by the one read port of each store. It then delivers one result per stored
// character on the output channel in visual order, left to right, each through the
// states S_EVO, S_EST and S_EPUT, the last one flagged with last_result. The input
// is not ready from the last character until the final result of that line is in
// the output register; a stalled receiver holds that register and pauses the emission.
// base_rtl (address 0) is written over the APB port; the user is to write it only
// between lines, and the block itself does not enforce this. Reset empties the
// line, clears the overflow flag and sets base_rtl to 0.

module bidi_line_level_reorder_unit #(
    parameter int MAX_CHARS = bllr_pkg::MAX_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bllr_in_if.sink     i_in_ch,
    bllr_out_if.source  o_out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bllr_pkg::*;

    logic r_base_rtl;
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {31'd0, r_base_rtl} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_rtl <= 1'b0;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_base_rtl <= pwdata[0];
        end
    end

    assign i_in_ch.ready = in_ready;

    bllr_ctrl #(.MAX_CHARS(MAX_CHARS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_in_last  (i_in_ch.last_char),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bllr_datapath #(.MAX_CHARS(MAX_CHARS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_base_rtl      (r_base_rtl),
        .i_code_point    (i_in_ch.code_point),
        .i_byte_length   (i_in_ch.byte_length),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (o_out_ch.ready),
        .o_out_valid     (o_out_ch.valid),
        .o_logical_index (o_out_ch.logical_index),
        .o_char_level    (o_out_ch.char_level),
        .o_byte_offset   (o_out_ch.byte_offset),
        .o_byte_count    (o_out_ch.byte_count),
        .o_last_result   (o_out_ch.last_result),
        .o_overflow      (o_out_ch.overflow)
    );

`ifndef SYNTHESIS
    // The final character of a line starts resolution, so loading stops.
    a_last_stops_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready && i_in_ch.last_char) |=> !i_in_ch.ready)
        else $error("input still ready after the last character of a line");

    // While results of a line remain, no new line is taken.
    a_no_load_mid_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.ready && !o_out_ch.last_result) |-> !i_in_ch.ready)
        else $error("input ready while results of a line are pending");
`endif

endmodule

[hdl/bllr_ctrl.sv]
// Controller: line loading, sequencing of the resolution passes and result emission.
`timescale 1ns / 1ps

module bllr_ctrl #(
    parameter int MAX_CHARS = bllr_pkg::MAX_CHARS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  bllr_pkg::t_sts i_sts,
    output bllr_pkg::t_cmd o_cmd
);
    import bllr_pkg::*;

    localparam int IW = $clog2(MAX_CHARS);
    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam int PW = $clog2(MAX_CHARS + 2);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_PASS = 3'd1;
    localparam logic [2:0] S_EVO  = 3'd2;
    localparam logic [2:0] S_EST  = 3'd3;
    localparam logic [2:0] S_EPUT = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_c, n_c;
    t_pass         r_pass, n_pass;
    logic [IW-1:0] r_k, n_k;

    logic [PW-1:0] c_n;
    logic [PW-1:0] rd_pos, proc_pos;
    logic          bwd;

    assign c_n = PW'(r_cnt);
    assign bwd = (r_pass == P_W5B) || (r_pass == P_NPRE) || (r_pass == P_LVL);
    // Backward passes walk the line from its last character down to the first.
    assign rd_pos   = bwd ? (c_n - PW'(1) - r_c) : r_c;
    assign proc_pos = bwd ? (c_n + PW'(1) - r_c) : (r_c - PW'(2));

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_c        = r_c;
        n_pass     = r_pass;
        n_k        = r_k;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.pass = r_pass;
        case (r_state)
            S_LOAD: begin
                o_in_ready      = 1'b1;
                o_cmd.load_addr = IDX_W'(r_cnt[IW-1:0]);
                if (i_in_valid) begin
                    if (r_cnt < CW'(MAX_CHARS)) begin
                        o_cmd.load_we = 1'b1;
                        n_cnt         = r_cnt + CW'(1);
                    end else begin
                        o_cmd.load_drop = 1'b1;
                    end
                    if (i_in_last) begin
                        n_state = S_PASS;
                        n_pass  = P_W123;
                        n_c     = '0;
                    end
                end
            end
            S_PASS: begin
                o_cmd.rd_addr   = IDX_W'(rd_pos[IW-1:0]);
                o_cmd.proc_addr = IDX_W'(proc_pos[IW-1:0]);
                o_cmd.proc_en   = (r_c >= PW'(2));
                o_cmd.first     = (r_c == PW'(2));
                o_cmd.has_next  = (r_c <= c_n);
                n_c             = r_c + PW'(1);
                if (r_c == c_n + PW'(1)) begin
                    n_c = '0;
                    if (r_pass == P_ORD) begin
                        n_state = S_EVO;
                        n_k     = '0;
                    end else begin
                        n_pass = r_pass + 4'd1;
                    end
                end
            end
            S_EVO: begin
                o_cmd.rd_addr = IDX_W'(r_k);
                n_state       = S_EST;
            end
            S_EST: begin
                o_cmd.rd_addr = IDX_W'(r_k);
                o_cmd.emit_st = 1'b1;
                n_state       = S_EPUT;
            end
            S_EPUT: begin
                o_cmd.rd_addr = IDX_W'(r_k);
                o_cmd.emit_st = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (CW'(r_k) == r_cnt - CW'(1)) begin
                        o_cmd.emit_last  = 1'b1;
                        o_cmd.clear_line = 1'b1;
                        n_cnt            = '0;
                        n_state          = S_LOAD;
                    end else begin
                        n_k     = r_k + IW'(1);
                        n_state = S_EVO;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_c     <= '0;
            r_pass  <= P_W123;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_c     <= n_c;
            r_pass  <= n_pass;
            r_k     <= n_k;
        end
    end

endmodule

[hdl/bllr_datapath.sv]
// Datapath: character stores, the rule logic of each pass and the result register.
`timescale 1ns / 1ps

module bllr_datapath #(
    parameter int MAX_CHARS = bllr_pkg::MAX_CHARS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_base_rtl,
    input  logic [bllr_pkg::CP_W-1:0]  i_code_point,
    input  logic [bllr_pkg::LEN_W-1:0] i_byte_length,
    input  bllr_pkg::t_cmd            i_cmd,
    output bllr_pkg::t_sts            o_sts,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [bllr_pkg::IDX_W-1:0] o_logical_index,
    output logic [bllr_pkg::LVL_W-1:0] o_char_level,
    output logic [bllr_pkg::OFF_W-1:0] o_byte_offset,
    output logic [bllr_pkg::LEN_W-1:0] o_byte_count,
    output logic                      o_last_result,
    output logic                      o_overflow
);
    import bllr_pkg::*;

    localparam int IW = $clog2(MAX_CHARS);

    t_class           mem_oc [MAX_CHARS];
    t_class           mem_wc [MAX_CHARS];
    logic [LVL_W-1:0] mem_lv [MAX_CHARS];
    logic [IW-1:0]    mem_vo [MAX_CHARS];
    logic [OFF_W-1:0] mem_off[MAX_CHARS];
    logic [LEN_W-1:0] mem_len[MAX_CHARS];
    logic [2*IW-1:0]  mem_end[MAX_CHARS];

    t_class           r_q_oc, r_q_wc, r_cur_oc, r_cur_wc;
    logic [LVL_W-1:0] r_q_lv, r_cur_lv;
    logic [IW-1:0]    r_q_vo;
    logic [OFF_W-1:0] r_q_off;
    logic [LEN_W-1:0] r_q_len;
    logic [2*IW-1:0]  r_q_end, r_cur_end;

    t_class           r_prev, n_prev, r_strong, n_strong;
    logic             r_trail, n_trail;
    logic [LVL_W-1:0] r_plev, n_plev;
    logic [IW-1:0]    r_x0, n_x0, r_x1, n_x1;

    logic [BT_W-1:0]  r_bt;
    logic             r_ovf;

    logic [IW-1:0]    ra, rd_a, wa, idx, pos;
    logic [LEN_W-1:0] len_c;
    t_class           sos, t, nx, p_eff, s_eff, w, right, wc_wd;
    logic [LVL_W-1:0] base_lv, lvl, lv_wd;
    logic [2*IW-1:0]  end_wd;
    logic             wc_we, lv_we, vo_we, trail_eff;
    logic [IW-1:0]    eb, ed;

    assign rd_a  = i_cmd.rd_addr[IW-1:0];
    assign wa    = i_cmd.proc_addr[IW-1:0];
    assign idx   = wa;
    assign ra    = i_cmd.emit_st ? r_q_vo : rd_a;
    assign len_c = (i_byte_length == '0) ? LEN_W'(1) :
                   (i_byte_length > LEN_W'(4)) ? LEN_W'(4) : i_byte_length;

    assign sos     = i_base_rtl ? C_R : C_L;
    assign base_lv = {1'b0, i_base_rtl};
    assign t       = r_cur_wc;
    assign nx      = r_q_wc;
    assign p_eff   = i_cmd.first ? sos : r_prev;
    assign s_eff   = i_cmd.first ? sos : r_strong;
    assign {eb, ed} = r_cur_end;

    always_comb begin
        n_prev    = r_prev;
        n_strong  = r_strong;
        n_trail   = r_trail;
        n_plev    = r_plev;
        n_x0      = r_x0;
        n_x1      = r_x1;
        wc_wd     = t;
        lv_wd     = base_lv;
        end_wd    = {r_x0, r_x1};
        pos       = idx;
        w         = t;
        right     = C_L;
        lvl       = base_lv;
        trail_eff = i_cmd.first | r_trail;
        wc_we     = 1'b0;
        lv_we     = 1'b0;
        vo_we     = 1'b0;
        case (i_cmd.pass)
            P_W123: begin
                wc_we = i_cmd.proc_en;
                w     = (r_cur_oc == C_NSM) ? p_eff : r_cur_oc;
                n_prev   = w;
                n_strong = (w == C_L || w == C_R || w == C_AL) ? w : s_eff;
                if (w == C_EN && s_eff == C_AL) wc_wd = C_AN;
                else if (w == C_AL) wc_wd = C_R;
                else wc_wd = w;
            end
            P_W4: begin
                wc_we = i_cmd.proc_en;
                if (!i_cmd.first && i_cmd.has_next) begin
                    if (t == C_ES && r_prev == C_EN && nx == C_EN) wc_wd = C_EN;
                    else if (t == C_CS && r_prev == nx && (r_prev == C_EN || r_prev == C_AN))
                        wc_wd = r_prev;
                end
                n_prev = wc_wd;
            end
            P_W5F, P_W5B: begin
                // The neighbor is the one handled just before, in either direction.
                wc_we = i_cmd.proc_en;
                if (!i_cmd.first && t == C_ET && r_prev == C_EN) wc_wd = C_EN;
                n_prev = wc_wd;
            end
            P_W67: begin
                wc_we = i_cmd.proc_en;
                w     = (t == C_ES || t == C_ET || t == C_CS) ? C_ON : t;
                if (w == C_EN && s_eff == C_L) w = C_L;
                n_strong = (w == C_L || w == C_R) ? w : s_eff;
                wc_wd    = w;
            end
            P_NPRE: begin
                wc_we = i_cmd.proc_en;
                if (is_neutral(t)) begin
                    wc_wd    = (s_eff == C_R) ? C_NRR : C_NRL;
                    n_strong = s_eff;
                end else begin
                    n_strong = n_view(t);
                end
            end
            P_NRES: begin
                wc_we = i_cmd.proc_en;
                if (t == C_NRL || t == C_NRR) begin
                    right = (t == C_NRR) ? C_R : C_L;
                    if (s_eff == C_L && right == C_L) wc_wd = C_L;
                    else if (s_eff == C_R && right == C_R) wc_wd = C_R;
                    else wc_wd = sos;
                    n_strong = s_eff;
                end else begin
                    n_strong = n_view(t);
                end
            end
            P_LVL: begin
                lv_we = i_cmd.proc_en;
                if (!i_base_rtl) begin
                    if (t == C_R) lvl = LV_1;
                    else if (t == C_AN || t == C_EN) lvl = LV_2;
                    else lvl = LV_0;
                end else if (t == C_L || t == C_EN || t == C_AN) begin
                    lvl = LV_2;
                end else begin
                    lvl = LV_1;
                end
                // Separators and the whitespace before them or at line end fall back.
                if (r_cur_oc == C_B || r_cur_oc == C_S) begin
                    lvl     = base_lv;
                    n_trail = 1'b1;
                end else if (r_cur_oc == C_WS) begin
                    if (trail_eff) lvl = base_lv;
                    n_trail = trail_eff;
                end else begin
                    n_trail = 1'b0;
                end
                lv_wd = lvl;
                if (lvl != LV_0 && (i_cmd.first || r_plev == LV_0)) n_x0 = idx;
                if (lvl == LV_2 && (i_cmd.first || r_plev != LV_2)) n_x1 = idx;
                end_wd = {n_x0, n_x1};
                n_plev = lvl;
            end
            P_ORD: begin
                vo_we = i_cmd.proc_en;
                if (r_cur_lv != LV_0 && (i_cmd.first || r_plev == LV_0)) n_x0 = idx;
                if (r_cur_lv == LV_2 && (i_cmd.first || r_plev != LV_2)) n_x1 = idx;
                n_plev = r_cur_lv;
                // Mirror within the outer run, and a second time within the inner run.
                if (r_cur_lv == LV_0) pos = idx;
                else if (r_cur_lv == LV_1) pos = n_x0 + eb - idx;
                else pos = n_x0 + eb - n_x1 - ed + idx;
            end
            default: begin
                wc_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) mem_oc[i_cmd.load_addr[IW-1:0]] <= classify(i_code_point);
        r_q_oc <= mem_oc[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (wc_we) mem_wc[wa] <= wc_wd;
        r_q_wc <= mem_wc[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (lv_we) mem_lv[wa] <= lv_wd;
        r_q_lv <= mem_lv[ra];
    end

    always_ff @(posedge i_clk) begin
        if (lv_we) mem_end[wa] <= end_wd;
        r_q_end <= mem_end[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (vo_we) mem_vo[pos] <= idx;
        r_q_vo <= mem_vo[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) mem_off[i_cmd.load_addr[IW-1:0]] <= r_bt[OFF_W-1:0];
        r_q_off <= mem_off[ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) mem_len[i_cmd.load_addr[IW-1:0]] <= len_c;
        r_q_len <= mem_len[ra];
    end

    always_ff @(posedge i_clk) begin
        r_cur_oc  <= r_q_oc;
        r_cur_wc  <= r_q_wc;
        r_cur_lv  <= r_q_lv;
        r_cur_end <= r_q_end;
        if (i_cmd.proc_en) begin
            r_prev   <= n_prev;
            r_strong <= n_strong;
            r_trail  <= n_trail;
            r_plev   <= n_plev;
            r_x0     <= n_x0;
            r_x1     <= n_x1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bt  <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.clear_line) begin
            r_bt  <= '0;
            r_ovf <= 1'b0;
        end else begin
            if (i_cmd.load_we) r_bt <= r_bt + BT_W'(len_c);
            if (i_cmd.load_drop) r_ovf <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_logical_index <= IDX_W'(r_q_vo);
            o_char_level    <= r_q_lv;
            o_byte_offset   <= r_q_off;
            o_byte_count    <= r_q_len;
            o_last_result   <= i_cmd.emit_last;
            o_overflow      <= r_ovf;
        end
    end

    assign o_sts.out_free = !o_out_valid || i_out_ready;

endmodule

[dv/bidi_line_level_reorder_unit_tb.sv]
// Self-checking testbench of the bidi line reorderer: directed and random lines, scoreboard.
`timescale 1ns / 1ps

module bidi_line_level_reorder_unit_tb;
    import bllr_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_char;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [LVL_W-1:0] lvl;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] cnt;
        logic             last;
        logic             ovf;
    } t_slot;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int MAXC = MAX_CHARS_DEF;
    localparam int HOLD_OFF_LEN = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    bllr_in_if  in_ch ();
    bllr_out_if out_ch ();

    bidi_line_level_reorder_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ch(in_ch.sink), .o_out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_char pending_chars[$];
    t_slot expected_slots[$];
    int    mismatches = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    logic  hold_off = 1'b0;
    event  hold_off_ev;
    longint cycle_count = 0;

    // Shadow of the block's line buffer and direction register.
    logic             base_rtl_m = 1'b0;
    t_class           cls_m[MAXC];
    logic [OFF_W-1:0] off_m[MAXC];
    logic [LEN_W-1:0] len_m[MAXC];
    int               count_m = 0;
    logic [BT_W-1:0]  total_m = '0;
    logic             ovf_m = 1'b0;

    function automatic t_class class_of(input logic [CP_W-1:0] cp);
        if (cp == 'h0A || cp == 'h0D || cp == 'h2029) return C_B;
        if (cp == 'h09 || cp == 'h0B || cp == 'h1F) return C_S;
        if (cp == 'h20 || cp == 'hA0 || cp == 'h202F || cp == 'h205F || cp == 'h3000 ||
            cp == 'h0C) return C_WS;
        if (cp >= 'h2000 && cp <= 'h200A) return C_WS;
        if (cp >= 'h0591 && cp <= 'h05BD) return C_NSM;
        if (cp == 'h05BF || cp == 'h05C1 || cp == 'h05C2 || cp == 'h05C4 || cp == 'h05C5 ||
            cp == 'h05C7) return C_NSM;
        if (cp >= 'h0590 && cp <= 'h05FF) return C_R;
        if (cp >= 'h07C0 && cp <= 'h085F) return C_R;
        if (cp >= 'hFB1D && cp <= 'hFB4F) return C_R;
        if ((cp >= 'h0610 && cp <= 'h061A) || (cp >= 'h064B && cp <= 'h065F) ||
            cp == 'h0670 || (cp >= 'h06D6 && cp <= 'h06DC) ||
            (cp >= 'h06DF && cp <= 'h06E4) || cp == 'h06E7 || cp == 'h06E8 ||
            (cp >= 'h06EA && cp <= 'h06ED)) return C_NSM;
        if (cp >= 'h0660 && cp <= 'h0669) return C_AN;
        if (cp >= 'h06F0 && cp <= 'h06F9) return C_EN;
        if ((cp >= 'h0600 && cp <= 'h06FF) || (cp >= 'h0750 && cp <= 'h077F) ||
            (cp >= 'h08A0 && cp <= 'h08FF) || (cp >= 'hFB50 && cp <= 'hFDFF) ||
            (cp >= 'hFE70 && cp <= 'hFEFF)) return C_AL;
        if ((cp >= 'h0300 && cp <= 'h036F) || (cp >= 'h1AB0 && cp <= 'h1AFF) ||
            (cp >= 'h1DC0 && cp <= 'h1DFF) || (cp >= 'h20D0 && cp <= 'h20FF)) return C_NSM;
        if ((cp >= 'h30 && cp <= 'h39) || (cp >= 'h2070 && cp <= 'h2079) ||
            (cp >= 'h2080 && cp <= 'h2089)) return C_EN;
        if (cp == 'h2C || cp == 'h2E || cp == 'h3A) return C_CS;
        if (cp == 'h2B || cp == 'h2D || cp == 'h207A || cp == 'h207B || cp == 'h208A ||
            cp == 'h208B) return C_ES;
        if (cp == 'h24 || cp == 'h25 || (cp >= 'hA2 && cp <= 'hA5) || cp == 'hB0 ||
            cp == 'h2030 || cp == 'h2031) return C_ET;
        if ((cp >= 'h41 && cp <= 'h5A) || (cp >= 'h61 && cp <= 'h7A)) return C_L;
        if (cp < 'h20 || cp == 'h7F) return C_ON;
        if ((cp >= 'h21 && cp <= 'h2F) || (cp >= 'h3A && cp <= 'h40) ||
            (cp >= 'h5B && cp <= 'h60) || (cp >= 'h7B && cp <= 'h7E)) return C_ON;
        return C_L;
    endfunction

    function automatic bit is_neut(input t_class c);
        return c == C_B || c == C_S || c == C_WS || c == C_ON;
    endfunction

    function automatic t_class strong_view(input t_class c);
        return (c == C_EN || c == C_AN) ? C_R : c;
    endfunction

    // Resolves the stored line and queues one expected slot per visual position.
    task automatic resolve_and_order();
        t_class t[MAXC];
        logic [LVL_W-1:0] lvl[MAXC];
        int ord[MAXC];
        int n, i, j, k, a, b, x, lv;
        t_class sos, prev, last_strong, lft, rgt, res;
        logic [LVL_W-1:0] base;
        bit trailing;
        t_slot s;
        n = count_m;
        base = {1'b0, base_rtl_m};
        sos = base_rtl_m ? C_R : C_L;
        for (i = 0; i < n; i++) t[i] = cls_m[i];
        prev = sos;
        for (i = 0; i < n; i++) begin
            if (t[i] == C_NSM) t[i] = prev;
            prev = t[i];
        end
        last_strong = sos;
        for (i = 0; i < n; i++) begin
            if (t[i] == C_EN && last_strong == C_AL) t[i] = C_AN;
            if (t[i] == C_L || t[i] == C_R || t[i] == C_AL) last_strong = t[i];
        end
        for (i = 0; i < n; i++) if (t[i] == C_AL) t[i] = C_R;
        for (i = 1; i + 1 < n; i++) begin
            if (t[i] == C_ES && t[i-1] == C_EN && t[i+1] == C_EN) t[i] = C_EN;
            else if (t[i] == C_CS && t[i-1] == t[i+1] && (t[i-1] == C_EN || t[i-1] == C_AN))
                t[i] = t[i-1];
        end
        for (i = 1; i < n; i++) if (t[i] == C_ET && t[i-1] == C_EN) t[i] = C_EN;
        for (i = n; i > 1; i--) if (t[i-2] == C_ET && t[i-1] == C_EN) t[i-2] = C_EN;
        for (i = 0; i < n; i++) if (t[i] == C_ES || t[i] == C_ET || t[i] == C_CS) t[i] = C_ON;
        last_strong = sos;
        for (i = 0; i < n; i++) begin
            if (t[i] == C_EN && last_strong == C_L) t[i] = C_L;
            if (t[i] == C_L || t[i] == C_R) last_strong = t[i];
        end
        i = 0;
        while (i < n) begin
            if (!is_neut(t[i])) begin
                i++;
            end else begin
                j = i;
                while (j < n && is_neut(t[j])) j++;
                lft = (i == 0) ? sos : strong_view(t[i-1]);
                rgt = (j == n) ? sos : strong_view(t[j]);
                if (lft == C_L && rgt == C_L) res = C_L;
                else if (lft == C_R && rgt == C_R) res = C_R;
                else res = sos;
                for (k = i; k < j; k++) t[k] = res;
                i = j;
            end
        end
        for (i = 0; i < n; i++) begin
            lvl[i] = base;
            if (base == LV_0) begin
                if (t[i] == C_R) lvl[i] = LV_1;
                else if (t[i] == C_AN || t[i] == C_EN) lvl[i] = LV_2;
            end else if (t[i] == C_L || t[i] == C_EN || t[i] == C_AN) begin
                lvl[i] = LV_2;
            end
        end
        // Separators and the whitespace before them or at line end drop to the base level.
        trailing = 1'b1;
        for (i = n; i > 0; i--) begin
            if (cls_m[i-1] == C_B || cls_m[i-1] == C_S) begin
                lvl[i-1] = base;
                trailing = 1'b1;
            end else if (cls_m[i-1] == C_WS) begin
                if (trailing) lvl[i-1] = base;
            end else begin
                trailing = 1'b0;
            end
        end
        for (i = 0; i < n; i++) ord[i] = i;
        for (lv = 2; lv >= 1; lv--) begin
            k = 0;
            while (k < n) begin
                if (lvl[ord[k]] < lv) begin
                    k++;
                end else begin
                    j = k;
                    while (j < n && lvl[ord[j]] >= lv) j++;
                    a = k;
                    b = j - 1;
                    while (a < b) begin
                        x = ord[a]; ord[a] = ord[b]; ord[b] = x;
                        a++; b--;
                    end
                    k = j;
                end
            end
        end
        for (k = 0; k < n; k++) begin
            s.idx = ord[k];
            s.lvl = lvl[ord[k]];
            s.off = off_m[ord[k]];
            s.cnt = len_m[ord[k]];
            s.last = (k + 1 == n);
            s.ovf = ovf_m;
            expected_slots = {expected_slots, s};
        end
        count_m = 0;
        total_m = '0;
        ovf_m = 1'b0;
    endtask

    task automatic store_char(input t_char c);
        logic [LEN_W-1:0] l;
        l = c.len;
        if (l == 0) l = 1;
        if (l > 4) l = 4;
        if (count_m < MAXC) begin
            cls_m[count_m] = class_of(c.cp);
            off_m[count_m] = total_m[OFF_W-1:0];
            len_m[count_m] = l;
            total_m = total_m + l;
            count_m++;
        end else begin
            ovf_m = 1'b1;
        end
        if (c.last) resolve_and_order();
    endtask

    // Driver: offers queued characters, idling at the current rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.code_point <= '0;
            in_ch.byte_length <= 3'd1;
            in_ch.last_char <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                store_char({in_ch.code_point, in_ch.byte_length, in_ch.last_char});
                void'(pending_chars.pop_front());
            end
            if ((!in_ch.valid || in_ch.ready) ) begin
                if (pending_chars.size() > (in_ch.valid && in_ch.ready ? 0 : 0) &&
                    pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    {in_ch.code_point, in_ch.byte_length, in_ch.last_char} <= pending_chars[0];
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started on request and counted in cycles here.
    always begin
        @(hold_off_ev);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Receiver: ready with random stalls or a long hold-off; checks each transfer.
    always @(posedge i_clk) begin
        t_slot got, exp_s;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.logical_index, out_ch.char_level, out_ch.byte_offset,
                       out_ch.byte_count, out_ch.last_result, out_ch.overflow};
                if (expected_slots.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    exp_s = expected_slots.pop_front();
                    if (got !== exp_s) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", exp_s, got);
                    end
                end
            end
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_chars.size() != 0 || in_ch.valid || expected_slots.size() != 0)
            @(posedge i_clk);
        // Lines without results may still be in the passes.
        repeat (13 * MAXC + 40) @(posedge i_clk);
    endtask

    task automatic write_base(input logic v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= {31'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        base_rtl_m = v;
    endtask

    function automatic logic [CP_W-1:0] pick_cp();
        logic [CP_W-1:0] set[16] = '{'h41, 'h05D0, 'h0627, 'h31, 'h0661, 'h2B, 'h24, 'h2C,
                                     'h0301, 'h2029, 'h09, 'h20, 'h21, 'h06F3, 'h2D, 'h2E};
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range('hFFFF);
            2: return $urandom_range('h7F);
            default: return set[$urandom_range(15)];
        endcase
    endfunction

    task automatic queue_line(input int n);
        t_char c;
        for (int i = 0; i < n; i++) begin
            c.cp = pick_cp();
            c.len = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
            c.last = (i == n - 1);
            pending_chars = {pending_chars, c};
        end
    endtask

    task automatic queue_text(input logic [CP_W-1:0] cps[$]);
        t_char c;
        foreach (cps[i]) begin
            c.cp = cps[i];
            c.len = 3'(1 + i % 4);
            c.last = (i == cps.size() - 1);
            pending_chars = {pending_chars, c};
        end
    endtask

    task automatic random_lines(input int chars);
        int sent;
        int n;
        sent = 0;
        while (sent < chars) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(66, 60) : $urandom_range(12, 1);
            queue_line(n);
            sent += n;
        end
    endtask

    initial begin
        logic [CP_W-1:0] txt[$];
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed lines: mixed scripts, numbers, separators, field extremes.
        txt = '{'h41, 'h20, 'h05D0, 'h05D1, 'h20, 'h31, 'h2C, 'h32, 'h20, 'h09, 'h20};
        queue_text(txt);
        txt = '{'h0627, 'h0301, 'h31, 'h2B, 'h32, 'h24, 'h0661, 'h2C, 'h0662, 'h2029};
        queue_text(txt);
        txt = '{'h1FFFFF, 'h0};
        queue_text(txt);
        pending_chars = {pending_chars, t_char'{'h0591, 3'd0, 1'b0}};
        pending_chars = {pending_chars, t_char'{'h06F5, 3'd7, 1'b1}};
        wait_drained();
        write_base(1'b1);
        txt = '{'h41, 'h20, 'h05D0, 'h31, 'h25, 'h0301, 'h20};
        queue_text(txt);
        queue_line(MAXC + 2);
        wait_drained();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 86 : 11) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 86 : 11) : 0;
            write_base(ph[0]);
            if (ph == 0) -> hold_off_ev;
            random_lines(80);
            wait_drained();
        end
        if (mismatches == 0 && expected_slots.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

[files.f]
hdl/bllr_pkg.sv
hdl/bllr_if.sv
hdl/bllr_ctrl.sv
hdl/bllr_datapath.sv
hdl/bidi_line_level_reorder_unit.sv
dv/bidi_line_level_reorder_unit_tb.sv
